// ----- src/bxf_pkg.sv -----
package bxf_pkg;

  localparam int LEN_W = 31;
  localparam int CNT_W = 29;
  localparam int WIN_N = 5;

  localparam logic [7:0] OP_CALL  = 8'hE8;
  localparam logic [7:0] OP_JMP   = 8'hE9;
  localparam logic [7:0] OP_ESC   = 8'h0F;
  localparam logic [7:0] JCC_MASK = 8'hF0;
  localparam logic [7:0] JCC_CODE = 8'h80;

  localparam logic [31:0] SWAP_MARK = 32'h80808080;

  // Configuration register indexes.
  localparam logic CFG_LEN  = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  // Opcode class of one byte, worked out when the byte enters.
  typedef struct packed {
    logic call_jmp;
    logic esc;
    logic jcc;
  } cls_t;

  // Entry of the queue between the front end and the back end.
  typedef struct packed {
    logic [7:0]       data;
    cls_t             cls;
    logic [LEN_W-1:0] pos;
    logic             last;
  } fitem_t;

  // Entry of the result queue.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [CNT_W-1:0] count;
  } oitem_t;

endpackage

// ----- src/bxf_fifo.sv -----
module bxf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- src/bxf_front.sv -----
module bxf_front import bxf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] buf_len,
  input  logic             take,
  input  logic [7:0]       data,
  output fitem_t           item
);

  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             last;
  cls_t             cls;

  // The byte is the last one of its buffer once its index reaches length - 1.
  assign last = (({1'b0, pos_r} + 32'd1) >= {1'b0, buf_len});

  always_comb begin
    cls.call_jmp = (data == OP_CALL) || (data == OP_JMP);
    cls.esc      = (data == OP_ESC);
    cls.jcc      = ((data & JCC_MASK) == JCC_CODE);
    pos_nxt      = last ? '0 : pos_r + 1'b1;
  end

  assign item = '{data: data, cls: cls, pos: pos_r, last: last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ----- src/bxf_back.sv -----
module bxf_back import bxf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] buf_len,
  input  logic             enc_mode,
  input  logic             in_empty,
  input  fitem_t           in_item,
  output logic             in_pop,
  input  logic             out_full,
  output logic             out_push,
  output oitem_t           out_item
);

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic             st_r, st_nxt;
  logic [7:0]       win_r [WIN_N];
  logic [7:0]       win_nxt [WIN_N];
  cls_t             wcls_r [WIN_N];
  cls_t             wcls_nxt [WIN_N];
  logic [2:0]       hc_r, hc_nxt;
  logic [2:0]       fl_r, fl_nxt;
  logic [31:0]      lop_r, lop_nxt;
  logic             lop_v_r, lop_v_nxt;
  logic [2:0]       skip_r, skip_nxt;
  logic             prev_r, prev_nxt;
  logic [CNT_W-1:0] tot_r, tot_nxt;
  logic [CNT_W-1:0] ftot_r, ftot_nxt;

  logic [7:0]       w [WIN_N];
  cls_t             wc [WIN_N];
  logic             scan, scanned, inrange, cand, close, take_op, patch;
  logic [31:0]      q, raw, conv;
  logic [2:0]       skip_s;
  logic             prev_s;
  logic [CNT_W-1:0] tot_s;

  function automatic logic [31:0] swap_marks(input logic [31:0] v);
    if ((v == 32'd0) || (v == SWAP_MARK)) begin
      return v ^ SWAP_MARK;
    end
    return v;
  endfunction

  // Relative/absolute conversion of one operand. n + 1 is the position just
  // past the operand; all sums are held in 34 bits so none of them wraps.
  function automatic logic [31:0] convert(input logic [31:0] op,
                                          input logic [LEN_W-1:0] n,
                                          input logic [LEN_W-1:0] len,
                                          input logic enc);
    logic [31:0] u;
    logic [33:0] v, b, s, a, g, d, e, f, r;
    u = swap_marks(op);
    v = {{2{u[31]}}, u};
    b = {3'b000, n} + 34'd1;
    s = {3'b000, len};
    a = v + b;
    g = a - s;
    d = v - s;
    e = v - b;
    f = v + s;
    r = v;
    if (enc) begin
      if (!a[33] && g[33]) begin
        r = a;
      end else if (!g[33] && d[33]) begin
        r = d;
      end
    end else begin
      if (!v[33] && d[33]) begin
        r = e;
      end else if (!a[33] && v[33]) begin
        r = f;
      end
    end
    return swap_marks(r[31:0]);
  endfunction

  // Window with the incoming byte placed behind the held ones, then the scan
  // of the oldest byte once four bytes of lookahead are present.
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      w[i]  = (hc_r == 3'(i)) ? in_item.data : win_r[i];
      wc[i] = (hc_r == 3'(i)) ? in_item.cls : wcls_r[i];
    end
    scan    = (hc_r == 3'd4);
    scanned = (skip_r == 3'd0);
    inrange = (in_item.pos < buf_len);
    cand    = scan && scanned && inrange &&
              (wc[0].call_jmp || (prev_r && wc[0].jcc));
    q       = {1'b0, in_item.pos} - 32'd3;
    close   = lop_v_r && ((q - lop_r) < 32'd4);
    take_op = cand && !close;
    raw     = {w[4], w[3], w[2], w[1]};
    conv    = convert(raw, in_item.pos, buf_len, enc_mode);
    patch   = take_op && (conv != raw);
    if (patch) begin
      w[1] = conv[7:0];
      w[2] = conv[15:8];
      w[3] = conv[23:16];
      w[4] = conv[31:24];
    end
    if (patch) begin
      skip_s = 3'd4;
    end else if (scan && !scanned) begin
      skip_s = skip_r - 1'b1;
    end else begin
      skip_s = skip_r;
    end
    if (patch) begin
      prev_s = 1'b0;
    end else if (scan) begin
      prev_s = scanned && wc[0].esc;
    end else begin
      prev_s = prev_r;
    end
    tot_s = tot_r + CNT_W'(patch);
  end

  always_comb begin
    st_nxt    = st_r;
    win_nxt   = win_r;
    wcls_nxt  = wcls_r;
    hc_nxt    = hc_r;
    fl_nxt    = fl_r;
    lop_nxt   = lop_r;
    lop_v_nxt = lop_v_r;
    skip_nxt  = skip_r;
    prev_nxt  = prev_r;
    tot_nxt   = tot_r;
    ftot_nxt  = ftot_r;
    in_pop    = 1'b0;
    out_push  = 1'b0;
    out_item  = '0;
    case (st_r)
      ST_RUN: begin
        if (!in_empty) begin
          if (in_item.last) begin
            // End of buffer: keep the window for draining, restart the stream.
            in_pop    = 1'b1;
            win_nxt   = w;
            wcls_nxt  = wc;
            fl_nxt    = hc_r + 1'b1;
            ftot_nxt  = tot_s;
            hc_nxt    = '0;
            lop_v_nxt = 1'b0;
            skip_nxt  = '0;
            prev_nxt  = 1'b0;
            tot_nxt   = '0;
            st_nxt    = ST_FLUSH;
          end else if (!scan) begin
            in_pop   = 1'b1;
            win_nxt  = w;
            wcls_nxt = wc;
            hc_nxt   = hc_r + 1'b1;
          end else if (!out_full) begin
            in_pop        = 1'b1;
            out_push      = 1'b1;
            out_item.data = w[0];
            for (int i = 0; i < WIN_N - 1; i++) begin
              win_nxt[i]  = w[i + 1];
              wcls_nxt[i] = wc[i + 1];
            end
            skip_nxt = skip_s;
            prev_nxt = prev_s;
            tot_nxt  = tot_s;
            if (take_op) begin
              lop_nxt   = q;
              lop_v_nxt = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!out_full) begin
          out_push       = 1'b1;
          out_item.data  = win_r[0];
          out_item.last  = (fl_r == 3'd1);
          out_item.count = (fl_r == 3'd1) ? ftot_r : '0;
          for (int i = 0; i < WIN_N - 1; i++) begin
            win_nxt[i] = win_r[i + 1];
          end
          fl_nxt = fl_r - 1'b1;
          if (fl_r == 3'd1) begin
            st_nxt = ST_RUN;
          end
        end
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_RUN;
      hc_r    <= '0;
      fl_r    <= '0;
      lop_v_r <= 1'b0;
      skip_r  <= '0;
      prev_r  <= 1'b0;
      tot_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      hc_r    <= hc_nxt;
      fl_r    <= fl_nxt;
      lop_v_r <= lop_v_nxt;
      skip_r  <= skip_nxt;
      prev_r  <= prev_nxt;
      tot_r   <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    wcls_r <= wcls_nxt;
    lop_r  <= lop_nxt;
    ftot_r <= ftot_nxt;
  end

endmodule

// ----- src/x86_branch_address_filter_top.sv -----
// Channel  Handshake            Payload
// input    in_push / in_full    in_byte[7:0]
// result   out_pop / out_empty  out_byte[7:0], out_is_last, out_patched_count[28:0]
// config   cfg_we               cfg_index (0 buffer length, 1 encode mode), cfg_data[30:0]
//
// One byte is taken per cycle while the input queue is not full; a byte leaves the back
// end once the byte four places after it has arrived there.
// At the end of a buffer the back end drains up to five window bytes, one per cycle while
// the result queue is not full, through its single write port; input still queues.
// Reset is synchronous and active low and empties both queues and clears the stream state.
// A stall on the result side fills the result queue, then the input queue, then raises full.
module x86_branch_address_filter_top import bxf_pkg::*; #(
  parameter int FQ_DEPTH = 4,
  parameter int OQ_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [7:0]       in_byte,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_byte,
  output logic             out_is_last,
  output logic [CNT_W-1:0] out_patched_count,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  logic [LEN_W-1:0] len_r;
  logic             enc_r;
  logic             take;
  fitem_t           f_item, b_item;
  logic             fq_empty, fq_pop;
  logic             oq_full, oq_push;
  oitem_t           o_wr, o_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      enc_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEN:  len_r <= cfg_data;
        CFG_MODE: enc_r <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  assign take = in_push && !in_full;

  bxf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .buf_len (len_r),
    .take    (take),
    .data    (in_byte),
    .item    (f_item)
  );

  bxf_fifo #(.W($bits(fitem_t)), .DEPTH(FQ_DEPTH)) u_fq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (take),
    .wr_data (f_item),
    .full    (in_full),
    .rd_en   (fq_pop),
    .rd_data (b_item),
    .empty   (fq_empty)
  );

  bxf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .buf_len  (len_r),
    .enc_mode (enc_r),
    .in_empty (fq_empty),
    .in_item  (b_item),
    .in_pop   (fq_pop),
    .out_full (oq_full),
    .out_push (oq_push),
    .out_item (o_wr)
  );

  bxf_fifo #(.W($bits(oitem_t)), .DEPTH(OQ_DEPTH)) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (o_wr),
    .full    (oq_full),
    .rd_en   (out_pop),
    .rd_data (o_rd),
    .empty   (out_empty)
  );

  assign out_byte          = o_rd.data;
  assign out_is_last       = o_rd.last;
  assign out_patched_count = o_rd.count;

endmodule

// ----- src/bxf_checker.sv -----
module bxf_checker import bxf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_full,
  input logic             out_empty,
  input logic             out_pop,
  input logic [7:0]       out_byte,
  input logic             out_is_last,
  input logic [CNT_W-1:0] out_patched_count
);

  // A waiting result that is not taken stays on the ports.
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte)))
    else $error("result byte changed while stalled");

  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> ($stable(out_is_last) && $stable(out_patched_count)))
    else $error("result flags changed while stalled");

  // The count is only carried on the final byte of a buffer.
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_last) |-> (out_patched_count == '0))
    else $error("patched count on a byte that is not the last");

  // Right after reset both queues are empty.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

bind x86_branch_address_filter_top bxf_checker u_bxf_checker (.*);
